### rtl/chd_pkg.sv
`timescale 1ns / 1ps
// chd_pkg: shared types, constants and helper functions for the compass heading block.
// Depends on nothing; imported by every module under rtl/.
package chd_pkg;

    localparam int CORDIC_ITERATIONS   = 16;
    localparam int ANGLE_FRACTION_BITS = 8;
    localparam int TABLE_FRACTION_BITS = 16;
    localparam int TABLE_LENGTH        = 24;

    localparam int READ_W  = 16;
    localparam int XY_W    = 19;                        // headroom for CORDIC gain on 17-bit magnitudes
    localparam int ANG_W   = ANGLE_FRACTION_BITS + 11;  // covers +-1024 degrees
    localparam int HEAD_W  = 9;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [READ_W-1:0] t_reading;
    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [ANG_W-1:0]  t_angle;
    typedef logic [HEAD_W-1:0]        t_heading;
    typedef logic [CHAR_W-1:0]        t_char;

    localparam int     DEG_ONE  = 1 << ANGLE_FRACTION_BITS;
    localparam t_angle ANG_ZERO = '0;
    localparam t_angle ANG_P90  = t_angle'(90 * DEG_ONE);
    localparam t_angle ANG_M90  = t_angle'(-90 * DEG_ONE);
    localparam t_angle ANG_P180 = t_angle'(180 * DEG_ONE);
    localparam t_angle ANG_M180 = t_angle'(-180 * DEG_ONE);
    localparam t_angle ANG_360  = t_angle'(360 * DEG_ONE);

    localparam t_heading HEAD_MAX   = t_heading'(360);
    localparam t_char    ASCII_ZERO = t_char'(8'h30);

    // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
    localparam int ATAN_Q16 [TABLE_LENGTH] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // One classified sample travelling from the front to the back end
    typedef struct packed {
        logic     bypass;   // angle already exact, skip the rotations
        t_xy      x;
        t_xy      y;
        t_angle   z;
        t_reading rx;
        t_reading ry;
        t_reading rz;
    } t_item;

    typedef struct packed {
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } t_digits;

    // Table entry requantised to the accumulator's fraction, half up
    function automatic t_angle atan_entry(input int i);
        int s;
        int t;
        s = TABLE_FRACTION_BITS - ANGLE_FRACTION_BITS;
        t = (i < TABLE_LENGTH) ? ATAN_Q16[i] : 0;
        if (s == 0) begin
            return t_angle'(t);
        end
        return t_angle'((t + (1 << (s - 1))) >>> s);
    endfunction

    // Decimal split of a heading up to 360 by compare and subtract
    function automatic t_digits split_digits(input t_heading v);
        t_heading           r;
        logic [DIGIT_W-1:0] hd;
        logic [DIGIT_W-1:0] td;
        t_digits            d;
        r  = v;
        hd = '0;
        if (r >= t_heading'(300)) begin
            hd = DIGIT_W'(3);
            r  = r - t_heading'(300);
        end else if (r >= t_heading'(200)) begin
            hd = DIGIT_W'(2);
            r  = r - t_heading'(200);
        end else if (r >= t_heading'(100)) begin
            hd = DIGIT_W'(1);
            r  = r - t_heading'(100);
        end
        td = '0;
        for (int k = 9; k >= 1; k--) begin
            if (td == '0 && r >= t_heading'(k * 10)) begin
                td = DIGIT_W'(k);
            end
        end
        r      = r - t_heading'(td) * t_heading'(10);
        d.hund = hd;
        d.tens = td;
        d.ones = r[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

### rtl/chd_front.sv
`timescale 1ns / 1ps
// chd_front: takes input transactions, sorts out the exact-angle cases and folds
// the left half-plane onto the right. Depends on chd_pkg.
module chd_front (
    input  logic             i_valid,
    input  chd_pkg::t_reading i_x_reading,
    input  chd_pkg::t_reading i_y_reading,
    input  chd_pkg::t_reading i_z_reading,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output chd_pkg::t_item   o_item
);
    import chd_pkg::*;

    t_xy    w_x;
    t_xy    w_y;
    logic   w_x_zero;
    logic   w_y_zero;
    logic   w_x_neg;

    assign w_x      = t_xy'(i_x_reading);
    assign w_y      = t_xy'(i_y_reading);
    assign w_x_zero = (i_x_reading == '0);
    assign w_y_zero = (i_y_reading == '0);
    assign w_x_neg  = i_x_reading[READ_W-1];

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.rx     = i_x_reading;
        o_item.ry     = i_y_reading;
        o_item.rz     = i_z_reading;
        o_item.bypass = w_x_zero || w_y_zero;
        o_item.x      = w_x;
        o_item.y      = w_y;
        o_item.z      = ANG_ZERO;
        if (w_x_zero && w_y_zero) begin
            o_item.z = ANG_ZERO;
        end else if (w_y_zero) begin
            o_item.z = w_x_neg ? ANG_P180 : ANG_ZERO;
        end else if (w_x_zero) begin
            o_item.z = i_y_reading[READ_W-1] ? ANG_M90 : ANG_P90;
        end else if (w_x_neg) begin
            // rotate by 180 degrees into the right half-plane
            o_item.x = -w_x;
            o_item.y = -w_y;
            o_item.z = i_y_reading[READ_W-1] ? ANG_M180 : ANG_P180;
        end
    end

endmodule

### rtl/chd_queue.sv
`timescale 1ns / 1ps
// chd_queue: short first-in first-out buffer of classified samples between the
// front and back ends. Depends on chd_pkg.
module chd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chd_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output chd_pkg::t_item o_head
);
    import chd_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr;
    logic [QPTR_W-1:0]  n_rd;
    logic [QCNT_W-1:0]  n_count;
    logic               w_push;
    logic               w_pop;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_nonempty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

### rtl/chd_back.sv
`timescale 1ns / 1ps
// chd_back: unrolled CORDIC vectoring pipeline, heading clamp, decimal split and
// output register. Depends on chd_pkg.
module chd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_nonempty,
    input  chd_pkg::t_item    i_q_head,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output chd_pkg::t_heading o_heading_degrees,
    output chd_pkg::t_char    o_hundreds_char,
    output chd_pkg::t_char    o_tens_char,
    output chd_pkg::t_char    o_ones_char,
    output chd_pkg::t_reading o_x_out,
    output chd_pkg::t_reading o_y_out,
    output chd_pkg::t_reading o_z_out
);
    import chd_pkg::*;

    localparam int N = CORDIC_ITERATIONS;

    logic              w_en;
    logic [N:0]        r_vld;
    t_item             r_stg [N+1];
    t_item             n_stg [N+1];

    logic              r_hvld;
    t_heading          r_head;
    t_reading          r_hx;
    t_reading          r_hy;
    t_reading          r_hz;
    t_angle            w_sum;
    t_heading          n_head;

    logic              r_out_vld;
    t_heading          r_out_head;
    t_char             r_hund;
    t_char             r_tens;
    t_char             r_ones;
    t_reading          r_ox;
    t_reading          r_oy;
    t_reading          r_oz;
    t_digits           w_dig;

    // whole pipeline moves unless a finished result is held back
    assign w_en    = !(r_out_vld && i_stall);
    assign o_q_pop = w_en && i_q_nonempty;

    assign n_stg[0] = i_q_head;

    for (genvar k = 0; k < N; k++) begin : g_iter
        localparam t_angle STEP = atan_entry(k);
        t_xy w_dx;
        t_xy w_dy;
        assign w_dx = $signed(r_stg[k].y) >>> k;
        assign w_dy = $signed(r_stg[k].x) >>> k;
        always_comb begin
            n_stg[k+1] = r_stg[k];
            if (!r_stg[k].bypass) begin
                if (!r_stg[k].y[XY_W-1]) begin
                    n_stg[k+1].x = r_stg[k].x + w_dx;
                    n_stg[k+1].y = r_stg[k].y - w_dy;
                    n_stg[k+1].z = r_stg[k].z + STEP;
                end else begin
                    n_stg[k+1].x = r_stg[k].x - w_dx;
                    n_stg[k+1].y = r_stg[k].y + w_dy;
                    n_stg[k+1].z = r_stg[k].z - STEP;
                end
            end
        end
    end

    // shift to 0..360 degrees, clamp the residue, truncate to whole degrees
    assign w_sum = r_stg[N].z + ANG_P180;
    always_comb begin
        if (w_sum[ANG_W-1]) begin
            n_head = '0;
        end else if (w_sum > ANG_360) begin
            n_head = HEAD_MAX;
        end else begin
            n_head = w_sum[ANGLE_FRACTION_BITS +: HEAD_W];
        end
    end

    assign w_dig = split_digits(r_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_hvld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[N-1:0], i_q_nonempty};
            r_hvld    <= r_vld[N];
            r_out_vld <= r_hvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= N; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_head     <= n_head;
            r_hx       <= r_stg[N].rx;
            r_hy       <= r_stg[N].ry;
            r_hz       <= r_stg[N].rz;
            r_out_head <= r_head;
            r_hund     <= ASCII_ZERO + t_char'(w_dig.hund);
            r_tens     <= ASCII_ZERO + t_char'(w_dig.tens);
            r_ones     <= ASCII_ZERO + t_char'(w_dig.ones);
            r_ox       <= r_hx;
            r_oy       <= r_hy;
            r_oz       <= r_hz;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_heading_degrees = r_out_head;
    assign o_hundreds_char   = r_hund;
    assign o_tens_char       = r_tens;
    assign o_ones_char       = r_ones;
    assign o_x_out           = r_ox;
    assign o_y_out           = r_oy;
    assign o_z_out           = r_oz;

`ifndef SYNTH
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_head <= HEAD_MAX)
        else $error("heading above 360");
    a_digits_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((int'(r_hund) - int'(ASCII_ZERO)) * 100
                     + (int'(r_tens) - int'(ASCII_ZERO)) * 10
                     + (int'(r_ones) - int'(ASCII_ZERO)) == int'(r_out_head)))
        else $error("digits disagree with heading");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> $stable(r_vld) && $stable(r_hvld))
        else $error("pipeline moved while output held");
`endif

endmodule

### rtl/compass_heading_digits.sv
`timescale 1ns / 1ps
// compass_heading_digits: top level of the magnetometer heading block.
// Depends on chd_pkg, chd_front, chd_queue and chd_back.
//
// Usage
//   Input channel: i_valid with i_x_reading, i_y_reading, i_z_reading; the
//   block drives o_stall. A transaction is taken at a rising edge with
//   i_valid high and o_stall low.
//   Output channel: o_valid with the heading (0..360), its three ASCII
//   digits and the three readings passed through; the receiver drives
//   i_stall. A transaction completes at an edge with o_valid high and
//   i_stall low.
//   Path from input transaction to o_valid: one queue slot, one load
//   stage, one stage per CORDIC iteration, a clamp stage and the
//   digit/output register.
//   Throughput: one transaction per cycle while i_stall does not hold
//   o_valid; the unrolled CORDIC pipeline, one rotation per stage, sets this.
//   Stall: while o_valid is held by i_stall the back-end pipeline freezes;
//   the two-entry queue keeps taking input until it fills, then o_stall rises.
//   Reset (i_rst_n low, synchronous): pipeline valid bits and the queue
//   empty out; no result is pending afterwards and o_stall is low.
module compass_heading_digits (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  chd_pkg::t_reading i_x_reading,
    input  chd_pkg::t_reading i_y_reading,
    input  chd_pkg::t_reading i_z_reading,
    output logic              o_valid,
    input  logic              i_stall,
    output chd_pkg::t_heading o_heading_degrees,
    output chd_pkg::t_char    o_hundreds_char,
    output chd_pkg::t_char    o_tens_char,
    output chd_pkg::t_char    o_ones_char,
    output chd_pkg::t_reading o_x_out,
    output chd_pkg::t_reading o_y_out,
    output chd_pkg::t_reading o_z_out
);
    import chd_pkg::*;

    logic  w_push;
    t_item w_item;
    logic  w_full;
    logic  w_pop;
    logic  w_nonempty;
    t_item w_head;

    // front end: accept and classify (exact angles, half-plane fold)
    chd_front u_front (
        .i_valid     (i_valid),
        .i_x_reading (i_x_reading),
        .i_y_reading (i_y_reading),
        .i_z_reading (i_z_reading),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    // decouples input acceptance from output back-pressure
    chd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_item),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_head     (w_head)
    );

    // back end: rotations, clamp, decimal digits, output register
    chd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_nonempty      (w_nonempty),
        .i_q_head          (w_head),
        .o_q_pop           (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_heading_degrees (o_heading_degrees),
        .o_hundreds_char   (o_hundreds_char),
        .o_tens_char       (o_tens_char),
        .o_ones_char       (o_ones_char),
        .o_x_out           (o_x_out),
        .o_y_out           (o_y_out),
        .o_z_out           (o_z_out)
    );

endmodule
